// ===== hdl/bsiea_pkg.sv =====
// ---------------------------------------------------------------------------
// bsiea_pkg
// Shared types and codes for the shift, expand and add operand unit.
// ---------------------------------------------------------------------------
package bsiea_pkg;

    typedef enum logic [1:0] {
        FUNC_IMM_SHIFT = 2'd0,
        FUNC_REG_SHIFT = 2'd1,
        FUNC_EXPAND    = 2'd2,
        FUNC_ADC       = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_kind_t;

    // One operand request as held in the input register
    typedef struct packed {
        func_t       func;
        logic [31:0] value_a;
        logic [31:0] value_b;
        shift_kind_t shift_type;
        logic [7:0]  shift_amount;
        logic [11:0] imm_field;
        logic        carry_flag;
    } op_t;

    typedef struct packed {
        logic [31:0] result;
        logic        carry_out;
        logic        overflow;
    } res_t;

endpackage

// ===== hdl/bsiea_shifter.sv =====
// ---------------------------------------------------------------------------
// bsiea_shifter
// Operand decode and 32-bit barrel shifter with carry out, covering the
// immediate shift, register shift and immediate expansion operations.
// ---------------------------------------------------------------------------
module bsiea_shifter
(
    input  bsiea_pkg::op_t  op,
    output logic [31:0]     shift_res,
    output logic            shift_cout
);

    logic [31:0]            x;
    bsiea_pkg::shift_kind_t kind;
    logic [7:0]             amt;
    logic                   rrx;
    logic                   sign;
    logic                   big;
    logic                   exact32;
    logic [32:0]            lsl_wide;
    logic [32:0]            lsr_wide;
    logic signed [32:0]     asr_wide;
    logic [63:0]            ror_wide;

    // Operand decode
    always_comb
    begin
        x    = op.value_a;
        kind = op.shift_type;
        amt  = op.shift_amount;
        rrx  = 1'b0;
        unique case (op.func)
            bsiea_pkg::FUNC_IMM_SHIFT:
            begin
                amt = {3'b000, op.shift_amount[4:0]};
                if (op.shift_amount[4:0] == 5'd0)
                begin
                    if (op.shift_type == bsiea_pkg::SHIFT_ROR)
                        rrx = 1'b1;
                    else if (op.shift_type == bsiea_pkg::SHIFT_LSR ||
                             op.shift_type == bsiea_pkg::SHIFT_ASR)
                        amt = 8'd32;
                end
            end
            bsiea_pkg::FUNC_REG_SHIFT:
            begin
                amt = op.shift_amount;
            end
            bsiea_pkg::FUNC_EXPAND:
            begin
                x    = {24'd0, op.imm_field[7:0]};
                kind = bsiea_pkg::SHIFT_ROR;
                amt  = {3'b000, op.imm_field[11:8], 1'b0};
            end
            default:
            begin
                amt = op.shift_amount;
            end
        endcase
    end

    assign sign     = x[31];
    assign big      = (amt[7:5] != 3'd0);
    assign exact32  = (amt == 8'd32);
    assign lsl_wide = {1'b0, x} << amt[4:0];
    assign lsr_wide = {x, 1'b0} >> amt[4:0];
    assign asr_wide = $signed({x, 1'b0}) >>> amt[4:0];
    assign ror_wide = {x, x} >> amt[4:0];

    always_comb
    begin
        shift_res  = x;
        shift_cout = op.carry_flag;
        if (rrx)
        begin
            shift_res  = {op.carry_flag, x[31:1]};
            shift_cout = x[0];
        end
        else if (amt != 8'd0)
        begin
            case (kind)
                bsiea_pkg::SHIFT_LSL:
                begin
                    shift_res  = big ? 32'd0 : lsl_wide[31:0];
                    shift_cout = big ? (exact32 & x[0]) : lsl_wide[32];
                end
                bsiea_pkg::SHIFT_LSR:
                begin
                    shift_res  = big ? 32'd0 : lsr_wide[32:1];
                    shift_cout = big ? (exact32 & sign) : lsr_wide[0];
                end
                bsiea_pkg::SHIFT_ASR:
                begin
                    shift_res  = big ? {32{sign}} : asr_wide[32:1];
                    shift_cout = big ? sign : asr_wide[0];
                end
                default:
                begin
                    // amount mod 32 of zero leaves the word, carry from bit 31
                    shift_res  = ror_wide[31:0];
                    shift_cout = ror_wide[31];
                end
            endcase
        end
    end

endmodule

// ===== hdl/bsiea_adder.sv =====
// ---------------------------------------------------------------------------
// bsiea_adder
// 32-bit add with carry in, giving unsigned carry and signed overflow.
// ---------------------------------------------------------------------------
module bsiea_adder
(
    input  logic [31:0] value_a,
    input  logic [31:0] value_b,
    input  logic        carry_flag,
    output logic [31:0] sum,
    output logic        carry_out,
    output logic        overflow
);

    logic [32:0] sum_wide;

    assign sum_wide  = {1'b0, value_a} + {1'b0, value_b} + {32'd0, carry_flag};
    assign sum       = sum_wide[31:0];
    assign carry_out = sum_wide[32];
    // Overflow when both addends differ in sign from the sum
    assign overflow  = (value_a[31] ^ sum_wide[31]) & (value_b[31] ^ sum_wide[31]);

endmodule

// ===== hdl/barrel_shifter_imm_expand_adder.sv =====
// ---------------------------------------------------------------------------
// barrel_shifter_imm_expand_adder
// Operand unit: barrel shifter with carry, immediate expander and adder.
// ---------------------------------------------------------------------------
// The unit takes one operand request per clock and returns one result per
// request, in order. Each request passes through an input register, one
// level of shift or add logic, and a result register, whose output drives
// the master side.
// Throughput is one request per cycle; a stall on m_tready holds the result
// register and, only when both registers are full, drops s_tready.
module barrel_shifter_imm_expand_adder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // value_a[31:0], value_b[63:32], shift_type[65:64], shift_amount[73:66],
    // imm_field[85:74], carry_flag[86], zero pad[87]
    input  logic [87:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result[31:0], carry_out[32], overflow[33], zero pad[39:34]
    output logic [39:0] m_tdata
);

    logic            in_valid_reg;
    logic            in_valid_next;
    bsiea_pkg::op_t  op_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    bsiea_pkg::res_t res_reg;
    bsiea_pkg::res_t res_next;
    logic            out_ready;
    logic            s_fire;
    logic [31:0]     shift_res;
    logic            shift_cout;
    logic [31:0]     sum;
    logic            sum_cout;
    logic            sum_ovf;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (in_valid_reg && !out_ready);
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture a request
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg.func         <= bsiea_pkg::func_t'(s_tuser);
            op_reg.value_a      <= s_tdata[31:0];
            op_reg.value_b      <= s_tdata[63:32];
            op_reg.shift_type   <= bsiea_pkg::shift_kind_t'(s_tdata[65:64]);
            op_reg.shift_amount <= s_tdata[73:66];
            op_reg.imm_field    <= s_tdata[85:74];
            op_reg.carry_flag   <= s_tdata[86];
        end
    end

    bsiea_shifter u_shifter
    (
        .op         (op_reg),
        .shift_res  (shift_res),
        .shift_cout (shift_cout)
    );

    bsiea_adder u_adder
    (
        .value_a    (op_reg.value_a),
        .value_b    (op_reg.value_b),
        .carry_flag (op_reg.carry_flag),
        .sum        (sum),
        .carry_out  (sum_cout),
        .overflow   (sum_ovf)
    );

    always_comb
    begin
        unique case (op_reg.func)
            bsiea_pkg::FUNC_ADC:
            begin
                res_next.result    = sum;
                res_next.carry_out = sum_cout;
                res_next.overflow  = sum_ovf;
            end
            default:
            begin
                res_next.result    = shift_res;
                res_next.carry_out = shift_cout;
                res_next.overflow  = 1'b0;
            end
        endcase
    end

    // Advance into the result register whenever it is free and a request is held
    always_ff @(posedge clk)
    begin
        if (out_ready && in_valid_reg)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res_reg.overflow, res_reg.carry_out, res_reg.result};

endmodule

// ===== hdl/bsiea_checker.sv =====
// ---------------------------------------------------------------------------
// bsiea_checker
// Port-level checks on the operand unit, bound to its top level.
// ---------------------------------------------------------------------------
module bsiea_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [87:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result keeps its valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    // A stalled result keeps its data
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed under stall");

    // A free master side never back-pressures the slave side
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // An accepted request reaches the master side if m_tready is high while it sits in the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("request lost in pipeline");

    // Pad bits of a shown result are zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:34] == 6'd0))
        else $error("nonzero pad bits in m_tdata");

endmodule

bind barrel_shifter_imm_expand_adder bsiea_checker u_bsiea_checker (.*);
